// ----- hdl/sorted_name_catalog_unit_defines.svh -----
// Assertion macros shared by the sorted name catalog RTL.
`ifndef SORTED_NAME_CATALOG_UNIT_DEFINES_SVH
`define SORTED_NAME_CATALOG_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SNC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted name catalog check failed");
`define SNC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted name catalog check failed");
`else
`define SNC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SNC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/sncat_pkg.sv -----
// Package with the constants, types and helper functions of the sorted name catalog.
package sncat_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int NAME_LEN    = 32;
    localparam int IDX_W       = $clog2(NAME_LEN);
    localparam int LEN_W       = $clog2(NAME_LEN + 1);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUG_MAX     = 999;
    localparam int SUG_W       = 10;
    localparam int SUG_DEPTH   = SUG_MAX + 1;
    localparam int PAT_LEN     = 16;
    localparam int DIG_LO      = 9;
    localparam int DIG_HI      = 11;

    typedef logic [NAME_LEN-1:0][7:0] name_t;

    // Running comparison of the incoming name against one held entry.
    // CMP_LT means the incoming name sorts below the entry; CMP_SAME means
    // both names ended together and are equal.
    typedef enum logic [1:0] {
        CMP_EQ,
        CMP_LT,
        CMP_GT,
        CMP_SAME
    } cmp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIN,
        ST_SRD,
        ST_SCHK
    } state_t;

    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_TOO_LONG = 3'd2;
    localparam logic [2:0] STAT_FOUND    = 3'd3;
    localparam logic [2:0] STAT_NONE     = 3'd4;

    typedef struct packed {
        logic             step;
        logic             done;
        logic             ins;
        logic [IDX_W-1:0] idx;
        logic [7:0]       ch;
    } cell_ctl_t;

    // Lower-case form of the suggestion pattern; digit places hold zero.
    localparam logic [7:0] PAT_TEXT [PAT_LEN] = '{
        8'h6E, 8'h6F, 8'h74, 8'h65, 8'h62, 8'h6F, 8'h6F, 8'h6B, 8'h2D,
        8'h00, 8'h00, 8'h00, 8'h2E, 8'h74, 8'h6E, 8'h73
    };

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h41:8'h5A]}) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- hdl/sorted_name_catalog_unit.sv -----
// Top level of the sorted name catalog: control, suggestion bitmap and output register.
// Name bytes are taken one per cycle while idle; a last byte waits for an unread result.
// The finish state after it fills the output register as the cell row shifts in one step.
// A suggestion request probes numbers 1 to 999 in turn, a read state and a check state per
// number, through the bitmap memory read port, and returns the first free one or none.
// Synchronous active-low reset empties the catalog, then a clearing pass sweeps the bitmap
// one entry per cycle while s_ready stays low.
`include "sorted_name_catalog_unit_defines.svh"

module sorted_name_catalog_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_name_char,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [6:0]  m_position,
    output logic [9:0]  m_suggestion,
    output logic [6:0]  m_entry_total,
    output logic        m_truncated_flag
);

    localparam int LEN_W = sncat_pkg::LEN_W;
    localparam int CNT_W = sncat_pkg::CNT_W;
    localparam int SUG_W = sncat_pkg::SUG_W;

    // Control state.
    sncat_pkg::state_t     state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  trunc_reg, trunc_next;
    logic                  pat_ok_reg, pat_ok_next;
    logic [SUG_W-1:0]      pat_num_reg, pat_num_next;
    logic [SUG_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [SUG_W-1:0]      sug_n_reg, sug_n_next;

    // Incoming name buffer (payload, no reset).
    sncat_pkg::name_t      cand_reg, cand_next;
    sncat_pkg::name_t      cand_ins;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_status_reg, m_status_next;
    logic [6:0]            m_position_reg, m_position_next;
    logic [9:0]            m_suggestion_reg, m_suggestion_next;
    logic [6:0]            m_entry_total_reg, m_entry_total_next;
    logic                  m_trunc_reg, m_trunc_next;

    // Bitmap of suggestion numbers already used by held names.
    logic                  used_mem [sncat_pkg::SUG_DEPTH];
    logic                  mem_rd_reg;
    logic                  mem_we;
    logic [SUG_W-1:0]      mem_wa;
    logic                  mem_wd;

    logic                  accept;
    logic                  step_ok;
    logic                  fin_long;
    logic                  fin_full;
    logic                  fin_ins;
    logic [CNT_W-1:0]      position;
    sncat_pkg::cell_ctl_t  ctl;
    logic [7:0]            fch;
    logic [13:0]           num_calc;

    // A transaction that produces no result never touches the output
    // register, so name bytes keep flowing while a result waits.
    assign s_ready = (state_reg == sncat_pkg::ST_IDLE) &&
                     (!m_valid_reg || m_ready || (!s_mode && !s_last));
    assign accept  = s_valid && s_ready;

    // Bytes past the stored limit are counted but never stored or compared.
    assign step_ok  = (len_reg < LEN_W'(sncat_pkg::NAME_LEN - 1));
    assign fin_long = (len_reg > LEN_W'(sncat_pkg::NAME_LEN - 1));
    assign fin_full = (count_reg >= CNT_W'(sncat_pkg::MAX_ENTRIES));
    assign fin_ins  = (state_reg == sncat_pkg::ST_FIN) && !fin_long && !fin_full;

    assign ctl.step = accept && !s_mode && step_ok;
    assign ctl.done = (state_reg == sncat_pkg::ST_FIN);
    assign ctl.ins  = fin_ins;
    assign ctl.idx  = len_reg[sncat_pkg::IDX_W-1:0];
    assign ctl.ch   = s_name_char;

    // The stored name is zero padded past its length.
    always_comb begin
        for (int b = 0; b < sncat_pkg::NAME_LEN; b++) begin
            cand_ins[b] = (LEN_W'(b) < len_reg) ? cand_reg[b] : 8'h00;
        end
    end

    sncat_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cand     (cand_ins),
        .position (position)
    );

    assign fch      = sncat_pkg::fold(s_name_char);
    assign num_calc = 14'(pat_num_reg) * 14'd10 + 14'(s_name_char - 8'h30);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sncat_pkg::ST_CLEAR: begin
                if (clr_addr_reg == SUG_W'(sncat_pkg::SUG_MAX)) begin
                    state_next = sncat_pkg::ST_IDLE;
                end
            end
            sncat_pkg::ST_IDLE: begin
                if (accept && s_mode) begin
                    state_next = sncat_pkg::ST_SRD;
                end else if (accept && s_last) begin
                    state_next = sncat_pkg::ST_FIN;
                end
            end
            sncat_pkg::ST_FIN: begin
                state_next = sncat_pkg::ST_IDLE;
            end
            sncat_pkg::ST_SRD: begin
                state_next = sncat_pkg::ST_SCHK;
            end
            sncat_pkg::ST_SCHK: begin
                if (!mem_rd_reg || (sug_n_reg == SUG_W'(sncat_pkg::SUG_MAX))) begin
                    state_next = sncat_pkg::ST_IDLE;
                end else begin
                    state_next = sncat_pkg::ST_SRD;
                end
            end
            default: begin
                state_next = sncat_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        len_next           = len_reg;
        count_next         = count_reg;
        trunc_next         = trunc_reg;
        pat_ok_next        = pat_ok_reg;
        pat_num_next       = pat_num_reg;
        clr_addr_next      = clr_addr_reg;
        sug_n_next         = sug_n_reg;
        cand_next          = cand_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_position_next    = m_position_reg;
        m_suggestion_next  = m_suggestion_reg;
        m_entry_total_next = m_entry_total_reg;
        m_trunc_next       = m_trunc_reg;
        mem_we             = 1'b0;
        mem_wa             = clr_addr_reg;
        mem_wd             = 1'b0;

        case (state_reg)
            sncat_pkg::ST_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + SUG_W'(1);
            end
            sncat_pkg::ST_IDLE: begin
                if (accept && s_mode) begin
                    sug_n_next = SUG_W'(1);
                end else if (accept) begin
                    if (step_ok) begin
                        cand_next[ctl.idx] = s_name_char;
                    end
                    if (len_reg < LEN_W'(sncat_pkg::NAME_LEN)) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    // Track whether the name reads as the suggestion pattern.
                    if (len_reg < LEN_W'(sncat_pkg::PAT_LEN)) begin
                        if ((len_reg >= LEN_W'(sncat_pkg::DIG_LO)) &&
                            (len_reg <= LEN_W'(sncat_pkg::DIG_HI))) begin
                            if ((s_name_char < 8'h30) || (s_name_char > 8'h39)) begin
                                pat_ok_next = 1'b0;
                            end
                            pat_num_next = num_calc[SUG_W-1:0];
                        end else if (fch != sncat_pkg::PAT_TEXT[len_reg[3:0]]) begin
                            pat_ok_next = 1'b0;
                        end
                    end else if (len_reg == LEN_W'(sncat_pkg::PAT_LEN)) begin
                        if (s_name_char != 8'h00) begin
                            pat_ok_next = 1'b0;
                        end
                    end
                end
            end
            sncat_pkg::ST_FIN: begin
                len_next          = '0;
                pat_ok_next       = 1'b1;
                pat_num_next      = '0;
                m_valid_next      = 1'b1;
                m_position_next   = '0;
                m_suggestion_next = '0;
                if (fin_long) begin
                    m_status_next = sncat_pkg::STAT_TOO_LONG;
                end else if (fin_full) begin
                    trunc_next    = 1'b1;
                    m_status_next = sncat_pkg::STAT_FULL;
                end else begin
                    count_next      = count_reg + CNT_W'(1);
                    m_status_next   = sncat_pkg::STAT_INSERTED;
                    m_position_next = 7'(position);
                    if (pat_ok_reg && (len_reg >= LEN_W'(sncat_pkg::PAT_LEN))) begin
                        mem_we = 1'b1;
                        mem_wa = pat_num_reg;
                        mem_wd = 1'b1;
                    end
                end
                m_entry_total_next = 7'(count_next);
                m_trunc_next       = trunc_next;
            end
            sncat_pkg::ST_SRD: begin
            end
            sncat_pkg::ST_SCHK: begin
                if (!mem_rd_reg) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = sncat_pkg::STAT_FOUND;
                    m_suggestion_next  = sug_n_reg;
                end else if (sug_n_reg == SUG_W'(sncat_pkg::SUG_MAX)) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = sncat_pkg::STAT_NONE;
                    m_suggestion_next  = '0;
                end else begin
                    sug_n_next = sug_n_reg + SUG_W'(1);
                end
                m_position_next    = '0;
                m_entry_total_next = 7'(count_reg);
                m_trunc_next       = trunc_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sncat_pkg::ST_CLEAR;
            len_reg      <= '0;
            count_reg    <= '0;
            trunc_reg    <= 1'b0;
            pat_ok_reg   <= 1'b1;
            pat_num_reg  <= '0;
            clr_addr_reg <= '0;
            sug_n_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            trunc_reg    <= trunc_next;
            pat_ok_reg   <= pat_ok_next;
            pat_num_reg  <= pat_num_next;
            clr_addr_reg <= clr_addr_next;
            sug_n_reg    <= sug_n_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg          <= cand_next;
        m_status_reg      <= m_status_next;
        m_position_reg    <= m_position_next;
        m_suggestion_reg  <= m_suggestion_next;
        m_entry_total_reg <= m_entry_total_next;
        m_trunc_reg       <= m_trunc_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            used_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= used_mem[sug_n_reg];
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_position       = m_position_reg;
    assign m_suggestion     = m_suggestion_reg;
    assign m_entry_total    = m_entry_total_reg;
    assign m_truncated_flag = m_trunc_reg;

    // The catalog never holds more names than it has cells.
    `SNC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(sncat_pkg::MAX_ENTRIES))
    // A successful insertion grows the catalog by exactly one name.
    `SNC_ASSERT_NEXT(a_count_step, aclk, aresetn, fin_ins, count_reg == $past(count_reg) + CNT_W'(1))
    // A transaction is only taken while no multi-cycle operation runs.
    `SNC_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == sncat_pkg::ST_IDLE)
    // The truncated flag never falls once set.
    `SNC_ASSERT_NEXT(a_trunc_sticky, aclk, aresetn, trunc_reg, trunc_reg)

endmodule

// ----- hdl/sncat_cell.sv -----
// One catalog cell: holds a single name and tracks its order against the incoming name.
module sncat_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sncat_pkg::cell_ctl_t   ctl,
    input  sncat_pkg::name_t       cand,
    input  logic                   left_valid,
    input  logic                   left_gt,
    input  sncat_pkg::name_t       left_name,
    output logic                   valid_o,
    output logic                   gt_o,
    output sncat_pkg::name_t       name_o,
    output logic                   take_o
);

    logic              valid_reg, valid_next;
    sncat_pkg::name_t  name_reg, name_next;
    sncat_pkg::cmp_t   cmp_reg, cmp_next;
    logic [7:0]        ebyte;
    logic [7:0]        fx, fy;
    logic              take_left;

    assign ebyte = name_reg[ctl.idx];
    assign fx    = sncat_pkg::fold(ctl.ch);
    assign fy    = sncat_pkg::fold(ebyte);

    // The incoming name ends at the current length, so a still-equal entry
    // with more bytes sorts above it.
    assign gt_o = valid_reg && ((cmp_reg == sncat_pkg::CMP_LT) ||
                  ((cmp_reg == sncat_pkg::CMP_EQ) && (ebyte != 8'h00)));

    assign take_left = left_gt;
    assign take_o    = ctl.ins && !left_gt && (gt_o || (!valid_reg && left_valid));
    assign valid_o   = valid_reg;
    assign name_o    = name_reg;

    always_comb begin
        cmp_next = cmp_reg;
        if (ctl.done) begin
            cmp_next = sncat_pkg::CMP_EQ;
        end else if (ctl.step && (cmp_reg == sncat_pkg::CMP_EQ)) begin
            if ((ctl.ch == 8'h00) || (ebyte == 8'h00)) begin
                if (ctl.ch == ebyte) begin
                    cmp_next = sncat_pkg::CMP_SAME;
                end else if (ctl.ch == 8'h00) begin
                    cmp_next = sncat_pkg::CMP_LT;
                end else begin
                    cmp_next = sncat_pkg::CMP_GT;
                end
            end else if (fx < fy) begin
                cmp_next = sncat_pkg::CMP_LT;
            end else if (fx > fy) begin
                cmp_next = sncat_pkg::CMP_GT;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        name_next  = name_reg;
        if (ctl.ins && take_left) begin
            valid_next = left_valid;
            name_next  = left_name;
        end else if (take_o) begin
            valid_next = 1'b1;
            name_next  = cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cmp_reg   <= sncat_pkg::CMP_EQ;
        end else begin
            valid_reg <= valid_next;
            cmp_reg   <= cmp_next;
        end
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
    end

endmodule

// ----- hdl/sncat_chain.sv -----
// Row of catalog cells kept in sorted order, with the insertion position encoder.
`include "sorted_name_catalog_unit_defines.svh"

module sncat_chain (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sncat_pkg::cell_ctl_t           ctl,
    input  sncat_pkg::name_t               cand,
    output logic [sncat_pkg::CNT_W-1:0]    position
);

    localparam int N = sncat_pkg::MAX_ENTRIES;

    sncat_pkg::name_t  names [N];
    logic [N-1:0]      valid;
    logic [N-1:0]      gt;
    logic [N-1:0]      take;

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_head
            sncat_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .cand       (cand),
                .left_valid (1'b1),
                .left_gt    (1'b0),
                .left_name  ('0),
                .valid_o    (valid[i]),
                .gt_o       (gt[i]),
                .name_o     (names[i]),
                .take_o     (take[i])
            );
        end else begin : g_body
            sncat_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .cand       (cand),
                .left_valid (valid[i-1]),
                .left_gt    (gt[i-1]),
                .left_name  (names[i-1]),
                .valid_o    (valid[i]),
                .gt_o       (gt[i]),
                .name_o     (names[i]),
                .take_o     (take[i])
            );
        end
    end

    always_comb begin
        position = '0;
        for (int i = 0; i < N; i++) begin
            if (take[i]) begin
                position = position | sncat_pkg::CNT_W'(i);
            end
        end
    end

    // Exactly one cell takes the new name on an insertion.
    `SNC_ASSERT_IMP(a_one_taker, aclk, aresetn, ctl.ins, $onehot(take))
    // Occupied cells form a prefix of the row; checked as an empty head cell implying an empty row.
    `SNC_ASSERT_IMP(a_prefix, aclk, aresetn, !valid[0], valid == '0)

endmodule
